[hw/rtl/aabb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the collider table.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int TYPE_COUNT = 10;
	localparam logic [3:0] KIND_PLAYER_SHOT = 4'd3;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_MARK  = 2'd1;
	localparam logic [1:0] OP_PURGE = 2'd2;
	localparam logic [1:0] OP_SCAN  = 2'd3;

	localparam logic [2:0] RK_ADD   = 3'd0;
	localparam logic [2:0] RK_MARK  = 3'd1;
	localparam logic [2:0] RK_PURGE = 3'd2;
	localparam logic [2:0] RK_PAIR  = 3'd3;
	localparam logic [2:0] RK_ROW   = 3'd4;

	localparam logic CFG_LOW  = 1'b0;
	localparam logic CFG_HIGH = 1'b1;

	localparam logic [49:0] FILTER_LOW_RST  = 50'd73742016763422;
	localparam logic [49:0] FILTER_HIGH_RST = 50'd357893184450566;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic [3:0]         kind;
		logic               owner;
	} entry_t;

	typedef struct packed {
		logic       hit;
		logic       notify_a;
		logic       notify_b;
		logic       b_first;
	} pair_t;

endpackage
`default_nettype wire

[hw/rtl/aabb_pair_collision_table.sv]
// Add, mark and purge present their result in the cycle after acceptance;
// the next transaction is taken only once that result has left the output.
// Scan of a valid row i: slots above i are compared in turn, one pair report per
// hit, held under stall, then row done; an empty or out-of-range row: row done.
// Reset: arst_n clears valid/marked bits and control, loads the stock type mask;
// entry memory contents are undefined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pair_collision_table
// Collider table with add/mark/purge and sequenced row scans.
// ----------------------------------------------------------------------------
module aabb_pair_collision_table #(
	parameter int TABLE_SLOTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[1:0], slot_index[6:2], rect_x[22:7], rect_y[38:23], rect_w[53:39],
	// rect_h[68:54], coll_kind[72:69], has_callback[73], zero[79:74]
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// slot_a[4:0], slot_b[9:5], table_full[10], slot_hit[11], notify_a[12],
	// notify_b[13], b_first[14], zero[15]
	output logic [15:0]      m_tdata,
	// result_kind[2:0]
	output logic [2:0]       m_tuser,
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [49:0] cfg_wdata
);
	localparam int IW = $clog2(TABLE_SLOTS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ROWR = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_OUT  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t st_q;
	logic [49:0] flo_q, fhi_q;
	logic [TABLE_SLOTS-1:0] valid_q, marked_q;
	aabb_pkg::entry_t mem [TABLE_SLOTS];
	aabb_pkg::entry_t rd_q, row_q;
	logic [4:0] idx_q;
	logic [IW:0] k_q, kr_q;
	logic rdv_q;
	aabb_pkg::pair_t pr;
	logic [15:0] od_q;
	logic [2:0] ok_q;
	logic ol_q;
	logic ov_q;

	logic [1:0] op;
	logic [4:0] sidx;
	aabb_pkg::entry_t new_e;
	logic [IW:0] free_idx;
	logic accept;

	assign op = s_tdata[1:0];
	assign sidx = s_tdata[6:2];
	assign new_e = '{x: s_tdata[22:7], y: s_tdata[38:23], w: s_tdata[53:39],
		h: s_tdata[68:54], kind: s_tdata[72:69], owner: s_tdata[73]};
	assign s_tready = (st_q == ST_IDLE) && !ov_q;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = ov_q;
	assign m_tdata = od_q;
	assign m_tuser = ok_q;
	assign m_tlast = ol_q;

	always_comb begin
		free_idx = (IW+1)'(TABLE_SLOTS);
		for (int i = TABLE_SLOTS - 1; i >= 0; i--)
			if (!valid_q[i])
				free_idx = (IW+1)'(i);
	end

	aabb_pair_unit u_pair (
		.ea(row_q), .eb(rd_q), .filter_low(flo_q), .filter_high(fhi_q), .pair(pr)
	);

	always_ff @(posedge clk) begin
		if (accept && op == aabb_pkg::OP_ADD && free_idx < (IW+1)'(TABLE_SLOTS))
			mem[free_idx[IW-1:0]] <= new_e;
		rd_q <= mem[k_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			flo_q <= aabb_pkg::FILTER_LOW_RST;
			fhi_q <= aabb_pkg::FILTER_HIGH_RST;
			valid_q <= '0;
			marked_q <= '0;
			ov_q <= 1'b0;
			rdv_q <= 1'b0;
			idx_q <= '0;
			k_q <= '0;
			kr_q <= '0;
			row_q <= '0;
			od_q <= '0;
			ok_q <= '0;
			ol_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == aabb_pkg::CFG_LOW)
					flo_q <= cfg_wdata;
				else
					fhi_q <= cfg_wdata;
			end
			if (ov_q && m_tready)
				ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= sidx;
						case (op)
							aabb_pkg::OP_ADD: begin
								ov_q <= 1'b1; ol_q <= 1'b1; ok_q <= aabb_pkg::RK_ADD;
								if (free_idx < (IW+1)'(TABLE_SLOTS)) begin
									valid_q[free_idx[IW-1:0]] <= 1'b1;
									marked_q[free_idx[IW-1:0]] <= 1'b0;
									od_q <= {11'b0, 5'(free_idx)};
								end else
									od_q <= {5'b0, 1'b1, 10'b0};
							end
							aabb_pkg::OP_MARK: begin
								ov_q <= 1'b1; ol_q <= 1'b1; ok_q <= aabb_pkg::RK_MARK;
								if (6'(sidx) < 6'(TABLE_SLOTS) && valid_q[sidx[IW-1:0]]) begin
									marked_q[sidx[IW-1:0]] <= 1'b1;
									od_q <= {4'b0, 1'b1, 6'b0, sidx};
								end else
									od_q <= {11'b0, sidx};
							end
							aabb_pkg::OP_PURGE: begin
								ov_q <= 1'b1; ol_q <= 1'b1; ok_q <= aabb_pkg::RK_PURGE;
								od_q <= '0;
								valid_q <= valid_q & ~marked_q;
								marked_q <= '0;
							end
							default: begin
								k_q <= (IW+1)'(sidx);
								if (6'(sidx) < 6'(TABLE_SLOTS) && valid_q[sidx[IW-1:0]])
									st_q <= ST_ROWR;
								else
									st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ROWR: begin
					k_q <= k_q + 1'b1;
					rdv_q <= 1'b0;
					st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!rdv_q) begin
						row_q <= rd_q;
						rdv_q <= 1'b1;
						kr_q <= k_q;
						if (k_q >= (IW+1)'(TABLE_SLOTS))
							st_q <= ST_DONE;
						else
							k_q <= k_q + 1'b1;
					end else begin
						kr_q <= k_q;
						if (valid_q[kr_q[IW-1:0]] && pr.hit) begin
							ov_q <= 1'b1; ol_q <= 1'b0; ok_q <= aabb_pkg::RK_PAIR;
							od_q <= {1'b0, pr.b_first, pr.notify_b, pr.notify_a, 2'b00,
								5'(kr_q), idx_q};
							st_q <= ST_OUT;
						end else if (k_q >= (IW+1)'(TABLE_SLOTS))
							st_q <= ST_DONE;
						else
							k_q <= k_q + 1'b1;
					end
				end
				// kr_q already names the next partner and rd_q holds its entry
				ST_OUT: begin
					if (ov_q && m_tready) begin
						if (kr_q >= (IW+1)'(TABLE_SLOTS))
							st_q <= ST_DONE;
						else begin
							k_q <= kr_q + 1'b1;
							st_q <= ST_SCAN;
						end
					end
				end
				ST_DONE: begin
					if (!ov_q || m_tready) begin
						ov_q <= 1'b1; ol_q <= 1'b1; ok_q <= aabb_pkg::RK_ROW;
						od_q <= {11'b0, idx_q};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/aabb_pair_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pair_unit
// Shared overlap and type-mask decision for one slot pair.
// ----------------------------------------------------------------------------
module aabb_pair_unit (
	input  wire aabb_pkg::entry_t ea,
	input  wire aabb_pkg::entry_t eb,
	input  wire logic [49:0]      filter_low,
	input  wire logic [49:0]      filter_high,
	output aabb_pkg::pair_t       pair
);
	logic signed [17:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
	logic ovl, rab, rba;

	function automatic logic reacts(input logic [3:0] r, input logic [3:0] c,
		input logic [49:0] lo, input logic [49:0] hi);
		logic [49:0] reg_v;
		logic [3:0]  rr;
		logic [5:0]  pos;
		begin
			reg_v = (r < 4'd5) ? lo : hi;
			rr = (r < 4'd5) ? r : r - 4'd5;
			pos = 6'(rr) * 6'd10 + 6'(c);
			if (r > 4'd9 || c > 4'd9)
				reacts = 1'b0;
			else
				reacts = reg_v[pos];
		end
	endfunction

	always_comb begin
		ax0 = 18'(ea.x);
		ax1 = 18'(ea.x) + $signed({3'b0, ea.w});
		ay0 = 18'(ea.y);
		ay1 = 18'(ea.y) + $signed({3'b0, ea.h});
		bx0 = 18'(eb.x);
		bx1 = 18'(eb.x) + $signed({3'b0, eb.w});
		by0 = 18'(eb.y);
		by1 = 18'(eb.y) + $signed({3'b0, eb.h});
		ovl = (ax0 < bx1) && (ax1 > bx0) && (ay0 < by1) && (ay1 > by0);
		rab = reacts(ea.kind, eb.kind, filter_low, filter_high) && ea.owner;
		rba = reacts(eb.kind, ea.kind, filter_low, filter_high) && eb.owner;
		pair.hit = ovl && (rab || rba);
		pair.notify_a = rab;
		pair.notify_b = rab ? eb.owner : 1'b1;
		pair.b_first = rab && eb.owner && (ea.kind == aabb_pkg::KIND_PLAYER_SHOT);
	end
endmodule
`default_nettype wire

[hw/rtl/aabb_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_checker
// Port-level checks for the collider table.
// ----------------------------------------------------------------------------
module aabb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");
	a_pair_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == aabb_pkg::RK_PAIR |-> !m_tlast)
		else $error("pair marked last");
	a_pair_notify: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == aabb_pkg::RK_PAIR |-> m_tdata[12] || m_tdata[13])
		else $error("pair without notify");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("ready mid-transaction");
	a_one_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");
endmodule

bind aabb_pair_collision_table aabb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
